[hdl/i2p_pkg.sv]
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and character helpers for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int unsigned StackDepthDef = 32;

  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharNone   = 8'h00;

  typedef enum logic [1:0] {
    CLS_ALNUM,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OP
  } char_cls_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD,
    ST_POP,
    ST_PUSH,
    ST_END,
    ST_FRD,
    ST_FPOP,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    char_cls_e cls;
    logic      last;
    logic      cnt_zero;
    logic      cnt_one;
    logic      top_lparen;
    logic      top_pops;
    logic      can_emit;
    logic      fin_ok;
  } dp_status_t;

  typedef struct packed {
    logic accept;
    logic emit_char;
    logic emit_top;
    logic pop;
    logic push;
    logic set_err;
    logic fin;
  } dp_cmd_t;

  function automatic logic [1:0] rank_of(input logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    if ((c == CharPlus) || (c == CharMinus)) begin
      r = 2'd1;
    end else if ((c == CharStar) || (c == CharSlash)) begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic char_cls_e classify(input logic [7:0] c);
    char_cls_e k;
    if (((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
        ((c >= 8'h61) && (c <= 8'h7A))) begin
      k = CLS_ALNUM;
    end else if (c == CharLParen) begin
      k = CLS_LPAREN;
    end else if (c == CharRParen) begin
      k = CLS_RPAREN;
    end else begin
      k = CLS_OP;
    end
    return k;
  endfunction

endpackage

[hdl/i2p_ctrl.sv]
// ----------------------------------------------------------------------------
// i2p_ctrl
// Controller state machine: sequences dispatch, stack pops, pushes and the
// end-of-expression flush through commands to the datapath.
// ----------------------------------------------------------------------------
module i2p_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2p_pkg::dp_status_t status_i,
  output i2p_pkg::dp_cmd_t    cmd_o
);
  import i2p_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (status_i.cls)
          CLS_ALNUM:  if (status_i.can_emit) state_d = ST_END;
          CLS_LPAREN: state_d = ST_END;
          CLS_RPAREN: state_d = status_i.cnt_zero ? ST_END : ST_RD;
          CLS_OP:     state_d = status_i.cnt_zero ? ST_END : ST_RD;
          default:    state_d = ST_END;
        endcase
      end
      ST_RD: state_d = ST_POP;
      ST_POP: begin
        if (status_i.cls == CLS_RPAREN) begin
          if (status_i.top_lparen) begin
            state_d = ST_END;
          end else if (status_i.can_emit) begin
            state_d = status_i.cnt_one ? ST_END : ST_RD;
          end
        end else begin
          if (!status_i.top_pops) begin
            state_d = ST_PUSH;
          end else if (status_i.can_emit) begin
            state_d = status_i.cnt_one ? ST_PUSH : ST_RD;
          end
        end
      end
      ST_PUSH: state_d = ST_END;
      ST_END: begin
        state_d = (status_i.last && !status_i.cnt_zero) ? ST_FRD : ST_FIN;
      end
      ST_FRD: state_d = ST_FPOP;
      ST_FPOP: begin
        if (status_i.can_emit) state_d = status_i.cnt_one ? ST_FIN : ST_FRD;
      end
      ST_FIN: begin
        if (status_i.fin_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.accept = in_valid_i;
      ST_DISPATCH: begin
        unique case (status_i.cls)
          CLS_ALNUM:  cmd_o.emit_char = status_i.can_emit;
          CLS_LPAREN: cmd_o.push = 1'b1;
          CLS_RPAREN: cmd_o.set_err = status_i.cnt_zero;
          CLS_OP:     cmd_o.push = status_i.cnt_zero;
          default:    cmd_o = '0;
        endcase
      end
      ST_POP: begin
        if (status_i.cls == CLS_RPAREN) begin
          if (status_i.top_lparen) begin
            cmd_o.pop = 1'b1;
          end else if (status_i.can_emit) begin
            // The stack runs dry without a matching '('.
            cmd_o.emit_top = 1'b1;
            cmd_o.pop      = 1'b1;
            cmd_o.set_err  = status_i.cnt_one;
          end
        end else if (status_i.top_pops && status_i.can_emit) begin
          cmd_o.emit_top = 1'b1;
          cmd_o.pop      = 1'b1;
        end
      end
      ST_PUSH: cmd_o.push = 1'b1;
      ST_FPOP: begin
        cmd_o.emit_top = status_i.can_emit;
        cmd_o.pop      = status_i.can_emit;
      end
      ST_FIN: cmd_o.fin = status_i.fin_ok;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_DISPATCH))
    else $error("accepted transaction did not enter dispatch");

  a_pop_in_pop_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> (state_q == ST_POP || state_q == ST_FPOP))
    else $error("pop issued outside a pop state");

  a_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.emit_char, cmd_o.push, cmd_o.fin, cmd_o.pop}) <= 1)
    else $error("conflicting datapath commands");
`endif

endmodule

[hdl/i2p_dpath.sv]
// ----------------------------------------------------------------------------
// i2p_dpath
// Datapath: operator stack memory, item register, error flag, a one-entry
// pending result and the output register.
// ----------------------------------------------------------------------------
module i2p_dpath #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::StackDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_char_i,
  input  logic                expr_end_i,
  input  i2p_pkg::dp_cmd_t    cmd_i,
  output i2p_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_char_o,
  output logic                out_last_o,
  output logic                error_flag_o
);
  import i2p_pkg::*;

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic [7:0]      stack_mem [STACK_DEPTH];
  logic [7:0]      top_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;
  logic [7:0]      char_q;
  logic            last_q;
  logic            pend_valid_q, pend_valid_d;
  logic [7:0]      pend_char_q;
  logic            pend_err_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q;
  logic            out_last_q, out_err_q;
  logic [CntW-1:0] cnt_m1;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic            full, out_free, emit, out_load;
  logic [7:0]      emit_char;

  assign full     = (cnt_q >= CntMax);
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = cmd_i.emit_char || cmd_i.emit_top;
  assign emit_char = cmd_i.emit_char ? char_q : top_q;
  assign cnt_m1   = cnt_q - CntOne;
  assign rd_addr  = (cnt_q == '0) ? '0 : cnt_m1[AddrW-1:0];
  assign wr_addr  = cnt_q[AddrW-1:0];

  // The stack top is read every cycle, so it is valid in the cycle after the
  // count settles.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      stack_mem[wr_addr] <= char_q;
    end
    top_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= in_char_i;
      last_q <= expr_end_i;
    end
    if (emit) begin
      pend_char_q <= emit_char;
      pend_err_q  <= err_q;
    end
    if (out_load) begin
      if (cmd_i.fin && last_q) begin
        out_char_q <= pend_valid_q ? pend_char_q : CharNone;
        out_last_q <= 1'b1;
        out_err_q  <= err_q;
      end else begin
        out_char_q <= pend_char_q;
        out_last_q <= 1'b0;
        out_err_q  <= pend_err_q;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    if (cmd_i.pop) cnt_d = cnt_m1;
    if (cmd_i.push) begin
      if (full) err_d = 1'b1;
      else      cnt_d = cnt_q + CntOne;
    end
    if (cmd_i.set_err) err_d = 1'b1;
    if (cmd_i.fin && last_q) begin
      cnt_d = '0;
      err_d = 1'b0;
    end
  end

  // A new result pushes the pending one out; the finish step releases it.
  assign out_load = (emit && pend_valid_q) ||
                    (cmd_i.fin && (last_q || pend_valid_q));

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (emit)       pend_valid_d = 1'b1;
    if (cmd_i.fin)  pend_valid_d = 1'b0;
    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      err_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      err_q        <= err_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    status_o.cls        = classify(char_q);
    status_o.last       = last_q;
    status_o.cnt_zero   = (cnt_q == '0);
    status_o.cnt_one    = (cnt_q == CntOne);
    status_o.top_lparen = (top_q == CharLParen);
    status_o.top_pops   = (rank_of(top_q) >= rank_of(char_q));
    status_o.can_emit   = !pend_valid_q || out_free;
    status_o.fin_ok     = out_free || (!last_q && !pend_valid_q);
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_last_o   = out_last_q;
  assign error_flag_o = out_err_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("stack count beyond depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && last_q) |=> (cnt_q == '0 && !err_q && out_last_q && out_valid_q))
    else $error("expression end did not clear state");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (cnt_q != '0))
    else $error("pop from an empty stack");
`endif

endmodule

[hdl/infix_to_postfix_converter_top.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard infix to postfix converter, one character per transaction.
// ----------------------------------------------------------------------------
// Characters enter one per transaction and the block works on one character
// at a time, holding off the input until it is done. Between one accepted
// transaction and the next possible one, every character passes through the
// idle, dispatch, end and finish states; a ')' or an operator on a non-empty
// stack adds a read step and a pop step for every stack entry it examines,
// and such an operator then needs a push step of its own. An examined entry
// needs both steps because the stack is a memory with a registered read and
// the top is read again before every pop. The final character of an expression
// adds a read step and a pop step per entry still on the stack for the flush,
// and a stalled full output register adds waiting on top of that. The
// latest result is held back until the character is finished, so that the
// final result of an expression can carry out_last and the final error flag;
// an expression that yields nothing returns one character-zero result.
// error_flag is sticky within an expression and clears after its final result.
module infix_to_postfix_converter_top #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       expr_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       error_flag_o
);
  import i2p_pkg::*;

  dp_status_t status;
  dp_cmd_t    cmd;

  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2p_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_char_i    (in_char_i),
    .expr_end_i   (expr_end_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .out_last_o   (out_last_o),
    .error_flag_o (error_flag_o)
  );

endmodule
